### sv/mlcr_pkg.sv
package mlcr_pkg;

    // default build
    localparam int CELLS_DEF       = 6;
    localparam int SAMPLE_BITS_DEF = 24;

    // fixed widths
    localparam int MAX_CELLS = 6;
    localparam int SCALE_W   = 24;
    localparam int OFS_W     = 32;
    localparam int SUM_W     = 34;
    localparam int PROD_W    = OFS_W + SCALE_W;
    localparam int FORCE_W   = 25;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 10;
    localparam int TPM_W     = 16;
    localparam int HS_W      = 6;
    localparam int DIV_STEPS = SUM_W - 1;
    localparam int STEP_W    = 6;
    localparam int OUT_TDATA_W = 64;

    // register indexes
    localparam logic [2:0] REG_CALIB  = 3'd0;
    localparam logic [2:0] REG_TPM    = 3'd1;
    localparam logic [2:0] REG_SCALE0 = 3'd2;

    // reset values
    localparam logic [CNT_W-1:0] CALIB_RST = 10'd100;
    localparam logic [TPM_W-1:0] TPM_RST   = 16'd1000;
    localparam logic [SCALE_W-1:0] SCALE_RST [MAX_CELLS] = '{
        24'd77679, 24'd75833, 24'd80027, 24'd77846, 24'd77846, 24'd79692
    };

    // opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ZERO = 2'd1;
    localparam logic [1:0] OP_RUN  = 2'd2;
    localparam logic [1:0] OP_STOP = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_CLOCK = 2'd0;
    localparam logic [1:0] KIND_FORCE = 2'd1;
    localparam logic [1:0] KIND_TARE  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic put_clock;
        logic put_tare;
        logic mul;
        logic put_force;
        logic div_load;
        logic div_step;
        logic div_write;
        logic sum_clr;
    } t_cmd;

    typedef struct packed {
        logic force_frame;
        logic tare_done;
        logic out_free;
    } t_status;

endpackage

### sv/mlcr_ctrl.sv
module mlcr_ctrl #(
    parameter int CELLS = mlcr_pkg::CELLS_DEF,
    parameter int CW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mlcr_pkg::t_status i_st,
    output mlcr_pkg::t_cmd   o_cmd,
    output logic [CW-1:0]    o_cell
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_PUT    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_FMT    = 4'd4;
    localparam logic [3:0] S_DIVLD  = 4'd5;
    localparam logic [3:0] S_DIVRUN = 4'd6;
    localparam logic [3:0] S_DIVWR  = 4'd7;
    localparam logic [3:0] S_TPUT   = 4'd8;

    localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
    localparam logic [mlcr_pkg::STEP_W-1:0] LAST_STEP =
        mlcr_pkg::STEP_W'(mlcr_pkg::DIV_STEPS - 1);

    logic [3:0]                   r_state, n_state;
    logic [CW-1:0]                r_cell, n_cell;
    logic [mlcr_pkg::STEP_W-1:0]  r_step, n_step;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cell     = r_cell;

    always_comb begin
        n_state = r_state;
        n_cell  = r_cell;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_cell = '0;
                if (i_st.force_frame) n_state = S_MUL;
                else if (i_st.tare_done) n_state = S_DIVLD;
                else n_state = S_PUT;
            end
            S_PUT: begin
                if (i_st.out_free) begin
                    o_cmd.put_clock = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_FMT;
            end
            S_FMT: begin
                if (i_st.out_free) begin
                    o_cmd.put_force = 1'b1;
                    if (r_cell == LAST_CELL) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cell  = r_cell + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_DIVLD: begin
                o_cmd.div_load = 1'b1;
                n_step  = '0;
                n_state = S_DIVRUN;
            end
            S_DIVRUN: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) n_state = S_DIVWR;
            end
            S_DIVWR: begin
                o_cmd.div_write = 1'b1;
                if (r_cell == LAST_CELL) begin
                    o_cmd.sum_clr = 1'b1;
                    n_state = S_TPUT;
                end else begin
                    n_cell  = r_cell + 1'b1;
                    n_state = S_DIVLD;
                end
            end
            S_TPUT: begin
                if (i_st.out_free) begin
                    o_cmd.put_tare = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cell  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cell  <= n_cell;
            r_step  <= n_step;
        end
    end

endmodule

### sv/mlcr_dp.sv
module mlcr_dp #(
    parameter int CELLS       = mlcr_pkg::CELLS_DEF,
    parameter int SAMPLE_BITS = mlcr_pkg::SAMPLE_BITS_DEF,
    parameter int CW          = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [23:0]          i_cfg_data,
    input  logic [1:0]           i_op,
    input  logic [5:0]           i_lines,
    input  mlcr_pkg::t_cmd       i_cmd,
    input  logic [CW-1:0]        i_cell,
    output mlcr_pkg::t_status    o_st,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [mlcr_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic [1:0]           o_out_kind,
    output logic                 o_out_last
);

    localparam int SB  = SAMPLE_BITS;
    localparam int OW  = mlcr_pkg::OFS_W;
    localparam int SW  = mlcr_pkg::SUM_W;
    localparam int PW  = mlcr_pkg::PROD_W;
    localparam int FW  = mlcr_pkg::FORCE_W;
    localparam int TW  = mlcr_pkg::TIME_W;
    localparam int HW  = mlcr_pkg::HS_W;
    localparam logic [HW-1:0] HS_END = HW'(2 * (SB + 1));
    localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);

    // configuration
    logic [mlcr_pkg::CNT_W-1:0]   r_calib;
    logic [mlcr_pkg::TPM_W-1:0]   r_tpm;
    logic [mlcr_pkg::SCALE_W-1:0] r_scale [mlcr_pkg::MAX_CELLS];

    // item latch
    logic [1:0] r_op;
    logic [5:0] r_lines;

    // control state
    logic r_run, n_run, r_taring, n_taring, r_zp, n_zp, r_fa, n_fa, r_clk, n_clk;
    logic [HW-1:0] r_hs, n_hs;
    logic [mlcr_pkg::CNT_W-1:0] r_frames, n_frames;
    logic [mlcr_pkg::TPM_W-1:0] r_td, n_td;
    logic [TW-1:0] r_ms, n_ms, r_ft, n_ft;

    // data state
    logic [SB-1:0] r_shift [CELLS];
    logic [OW-1:0] r_ofs   [CELLS];
    logic [SW-1:0] r_sums  [CELLS];

    // multiply and divide
    logic [PW-1:0] r_prod;
    logic          r_pneg;
    logic [SW-2:0] r_dq;
    logic [mlcr_pkg::CNT_W-1:0] r_rem;
    logic          r_dneg;

    logic r_oval;
    logic [1:0] r_okind;
    logic [2:0] r_ocell;
    logic [FW-1:0] r_oforce;
    logic [TW-1:0] r_otime;
    logic r_olast, r_oclk;

    logic [mlcr_pkg::TPM_W-1:0] tpm, td_inc;
    logic [mlcr_pkg::CNT_W-1:0] cnt, fr_inc;
    logic [HW-1:0] hs_inc;
    logic shift_clr, shift_en, sum_add, sum_clr, tare_done, force_frame, out_free;

    assign tpm = (r_tpm == '0) ? mlcr_pkg::TPM_W'(1) : r_tpm;
    assign cnt = (r_calib == '0) ? mlcr_pkg::CNT_W'(1) : r_calib;
    assign out_free = !r_oval || i_out_ready;

    always_comb begin
        n_run = r_run; n_taring = r_taring; n_zp = r_zp; n_fa = r_fa; n_clk = r_clk;
        n_hs = r_hs; n_frames = r_frames; n_td = r_td; n_ms = r_ms; n_ft = r_ft;
        shift_clr = 1'b0; shift_en = 1'b0; sum_add = 1'b0; sum_clr = 1'b0;
        tare_done = 1'b0; force_frame = 1'b0;
        td_inc = r_td + 1'b1;
        hs_inc = r_hs + 1'b1;
        fr_inc = r_frames + 1'b1;
        if (i_cmd.exec) begin
            unique case (r_op)
                mlcr_pkg::OP_ZERO: begin
                    if (r_fa) begin
                        n_zp = 1'b1;
                    end else begin
                        n_taring = 1'b1;
                        n_frames = '0;
                        sum_clr  = 1'b1;
                    end
                end
                mlcr_pkg::OP_RUN:  n_run = 1'b1;
                mlcr_pkg::OP_STOP: n_run = 1'b0;
                default: begin
                    // millisecond counter
                    if (td_inc >= tpm) begin
                        n_td = '0;
                        n_ms = r_ms + 1'b1;
                    end else begin
                        n_td = td_inc;
                    end
                    if (!r_fa) begin
                        // all data lines low: converters ready
                        if ((r_lines[CELLS-1:0] == '0) && (r_run || r_taring)) begin
                            n_fa = 1'b1;
                            n_ft = n_ms;
                            shift_clr = 1'b1;
                            n_clk = 1'b1;
                            n_hs = HW'(1);
                        end
                    end else if (r_clk) begin
                        n_clk = 1'b0;
                        if (r_hs[HW-1:1] < (HW-1)'(SB)) shift_en = 1'b1;
                        n_hs = hs_inc;
                        if (hs_inc >= HS_END) begin
                            n_fa = 1'b0;
                            n_hs = '0;
                            if (r_taring) begin
                                sum_add  = 1'b1;
                                n_frames = fr_inc;
                                if (fr_inc >= cnt) begin
                                    tare_done = 1'b1;
                                    n_frames = '0;
                                    n_taring = 1'b0;
                                    n_ms = '0;
                                    n_td = '0;
                                end
                            end else if (r_run) begin
                                force_frame = 1'b1;
                            end
                            if (r_zp) begin
                                n_zp = 1'b0;
                                n_taring = 1'b1;
                                n_frames = '0;
                                // sums still needed by the divider on tare end
                                if (!tare_done) sum_clr = 1'b1;
                            end
                        end
                    end else begin
                        n_clk = 1'b1;
                        n_hs = hs_inc;
                    end
                end
            endcase
        end
    end

    assign o_st.force_frame = force_frame;
    assign o_st.tare_done   = tare_done;
    assign o_st.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= mlcr_pkg::CALIB_RST;
            r_tpm   <= mlcr_pkg::TPM_RST;
            for (int i = 0; i < mlcr_pkg::MAX_CELLS; i++) r_scale[i] <= mlcr_pkg::SCALE_RST[i];
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mlcr_pkg::REG_CALIB: r_calib <= i_cfg_data[mlcr_pkg::CNT_W-1:0];
                mlcr_pkg::REG_TPM:   r_tpm   <= i_cfg_data[mlcr_pkg::TPM_W-1:0];
                default: r_scale[3'(i_cfg_idx - mlcr_pkg::REG_SCALE0)] <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_taring <= 1'b1; r_zp <= 1'b0; r_fa <= 1'b0; r_clk <= 1'b0;
            r_hs <= '0; r_frames <= '0; r_td <= '0; r_ms <= '0; r_ft <= '0;
            r_oval <= 1'b0;
        end else begin
            r_run <= n_run; r_taring <= n_taring; r_zp <= n_zp; r_fa <= n_fa;
            r_clk <= n_clk; r_hs <= n_hs; r_frames <= n_frames; r_td <= n_td;
            r_ms <= n_ms; r_ft <= n_ft;
            if (i_cmd.put_clock || i_cmd.put_tare || i_cmd.put_force) r_oval <= 1'b1;
            else if (i_out_ready) r_oval <= 1'b0;
        end
    end

    // shift, sum and offset arrays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CELLS; c++) begin
                r_shift[c] <= '0;
                r_ofs[c]   <= '0;
                r_sums[c]  <= '0;
            end
        end else begin
            for (int c = 0; c < CELLS; c++) begin
                if (shift_clr) r_shift[c] <= '0;
                else if (shift_en) r_shift[c] <= {r_shift[c][SB-2:0], r_lines[c]};
                if (sum_clr || i_cmd.sum_clr) r_sums[c] <= '0;
                else if (sum_add)
                    r_sums[c] <= r_sums[c] + {{(SW-SB){r_shift[c][SB-1]}}, r_shift[c]};
            end
            if (i_cmd.div_write)
                r_ofs[i_cell] <= r_dneg ? (OW'(0) - r_dq[OW-1:0]) : r_dq[OW-1:0];
        end
    end

    // item latch, multiplier, divider, output payload
    logic [OW-1:0] rd_sel, diff, dmag;
    logic [SW-1:0] sum_sel, smag;
    logic [mlcr_pkg::CNT_W:0] rem_sh;
    logic [PW:0] rnd;
    logic [PW-24:0] rmag;
    logic [PW-24:0] rsgn;

    assign rd_sel  = {{(OW-SB){r_shift[i_cell][SB-1]}}, r_shift[i_cell]};
    assign diff    = rd_sel - r_ofs[i_cell];
    assign dmag    = diff[OW-1] ? (OW'(0) - diff) : diff;
    assign sum_sel = r_sums[i_cell];
    assign smag    = sum_sel[SW-1] ? (SW'(0) - sum_sel) : sum_sel;
    assign rem_sh  = {r_rem, r_dq[SW-2]};
    assign rnd     = {1'b0, r_prod} + (PW+1)'(1 << 23);
    assign rmag    = rnd[PW:24];
    assign rsgn    = r_pneg ? ((PW-23)'(0) - rmag) : rmag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_op;
            r_lines <= i_lines;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(dmag) * PW'(r_scale[i_cell]);
            r_pneg <= diff[OW-1];
        end
        if (i_cmd.div_load) begin
            r_dq   <= smag[SW-2:0];
            r_dneg <= sum_sel[SW-1];
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, cnt}) begin
                r_rem <= mlcr_pkg::CNT_W'(rem_sh - {1'b0, cnt});
                r_dq  <= {r_dq[SW-3:0], 1'b1};
            end else begin
                r_rem <= rem_sh[mlcr_pkg::CNT_W-1:0];
                r_dq  <= {r_dq[SW-3:0], 1'b0};
            end
        end
        if (i_cmd.put_clock || i_cmd.put_tare) begin
            r_okind  <= i_cmd.put_tare ? mlcr_pkg::KIND_TARE : mlcr_pkg::KIND_CLOCK;
            r_ocell  <= '0;
            r_oforce <= '0;
            r_otime  <= '0;
            r_olast  <= 1'b1;
            r_oclk   <= r_clk;
        end else if (i_cmd.put_force) begin
            r_okind  <= mlcr_pkg::KIND_FORCE;
            r_ocell  <= 3'(i_cell);
            r_oforce <= rsgn[FW-1:0];
            r_otime  <= r_ft;
            r_olast  <= (i_cell == LAST_CELL);
            r_oclk   <= r_clk;
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_kind  = r_okind;
    assign o_out_last  = r_olast;
    assign o_out_data  = {3'b000, r_otime, r_oforce, r_ocell, r_oclk};

endmodule

### sv/multi_load_cell_reader_tare_scale_core.sv
// an accepted tick or command is latched, executed, and its result registered
// input: one request at a time, taken only when idle; a force frame end holds the
//   input for one multiply and one output load per cell, plus output stalls
// tare end: a bit-serial divider runs for each cell, then the tare result is output
// reset: synchronous active low; registers take their defaults and a tare starts
module multi_load_cell_reader_tare_scale_core #(
    parameter int CELLS       = mlcr_pkg::CELLS_DEF,
    parameter int SAMPLE_BITS = mlcr_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // dout_lines[5:0], zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // clock_out, cell_res[2:0], force_cn[24:0],
                                        // time_ms[31:0], zero pad
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast    // last
);

    localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;

    mlcr_pkg::t_cmd    cmd;
    mlcr_pkg::t_status st;
    logic [CW-1:0]     cell_sel;

    // sequencer: one request at a time, multiply per cell, divide per cell on tare end
    mlcr_ctrl #(.CELLS(CELLS), .CW(CW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_cell     (cell_sel)
    );

    // converter clocking, tare sums, offsets and the output register
    mlcr_dp #(.CELLS(CELLS), .SAMPLE_BITS(SAMPLE_BITS), .CW(CW)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_lines     (s_axis_tdata[5:0]),
        .i_cmd       (cmd),
        .i_cell      (cell_sel),
        .o_st        (st),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
